FILE: sv/rxpf_pkg.sv
// rxpf_pkg: types and constants shared by the packet filter modules
package rxpf_pkg;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_RECV,
        PH_EMIT
    } t_phase;

    typedef enum logic [2:0] {
        V_ACCEPT     = 3'd0,
        V_RX_OFF     = 3'd1,
        V_BAD_STATUS = 3'd2,
        V_BAD_LENGTH = 3'd3,
        V_MISMATCH   = 3'd4,
        V_TOO_LONG   = 3'd5,
        V_STATION    = 3'd6,
        V_CRC        = 3'd7
    } t_verdict;

    // source of an emitted byte
    typedef enum logic [1:0] {
        SRC_MEM,
        SRC_STAT,
        SRC_SWAP
    } t_src;

    // register indexes on the config port
    localparam logic [1:0] CFG_RX_ENABLED     = 2'd0;
    localparam logic [1:0] CFG_STATION_ID     = 2'd1;
    localparam logic [1:0] CFG_MAX_BUFFER_LEN = 2'd2;

    localparam logic [15:0] ID_NONE    = 16'h0000;
    localparam logic [15:0] ID_ALL     = 16'hffff;
    localparam logic [15:0] CNT_MAX    = 16'hffff;
    localparam logic [6:0]  COUNT_MIN  = 7'd5;
    localparam logic [6:0]  LEN_OFFSET = 7'd3;
    localparam logic [7:0]  STAT_ADD   = 8'h80;
    localparam logic [7:0]  STAT_MASK  = 8'h7f;
    localparam logic [5:0]  MAX_LEN_RESET = 6'd62;

    typedef struct packed {
        logic        rx_enabled;
        logic [15:0] station_id;
        logic [5:0]  max_buffer_len;
    } t_cfg;

    // packet store port request
    typedef struct packed {
        logic       we;
        logic [6:0] waddr;
        logic [7:0] wdata;
        logic       re;
        logic [6:0] raddr;
    } t_mem_req;

endpackage

FILE: sv/rxpf_store.sv
// rxpf_store: packet byte store, one write and one registered read port
module rxpf_store #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic               i_clk,
    input  rxpf_pkg::t_mem_req i_req,
    output logic [7:0]         o_rdata
);
    localparam int AW = $clog2(BUFFER_BYTES);

    logic [7:0] r_mem [BUFFER_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[AW'(i_req.waddr)] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[AW'(i_req.raddr)];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/rxpf_ctrl.sv
// rxpf_ctrl: header checks, receive sequencing, counters and output words
module rxpf_ctrl #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rxpf_pkg::t_cfg     i_cfg,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic               i_first,
    input  logic [6:0]         i_count,
    input  logic               i_idle,
    input  logic [7:0]         i_byte,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [2:0]         o_verdict,
    output logic [7:0]         o_byte,
    output logic               o_last,
    output logic               o_needs_reset,
    output logic [15:0]        o_rec,
    output logic [15:0]        o_acc,
    output rxpf_pkg::t_mem_req o_req,
    input  logic [7:0]         i_rdata
);
    import rxpf_pkg::*;

    localparam logic [8:0] BUF_CAP = 9'(BUFFER_BYTES);

    t_phase      r_phase, n_phase;
    logic [6:0]  r_widx, n_widx;
    logic [6:0]  r_expect, n_expect;
    logic [6:0]  r_eidx, n_eidx;
    logic [15:0] r_rec, n_rec;
    logic [15:0] r_acc, n_acc;
    logic [15:0] r_sid, n_sid;
    logic [7:0]  r_prev, n_prev;
    logic [7:0]  r_stat, n_stat;
    // read stage
    logic        r_rv, n_rv;
    t_src        r_rsrc, n_rsrc;
    logic        r_rlast, n_rlast;
    // output register
    logic        r_ov, n_ov;
    t_verdict    r_verdict, n_verdict;
    logic [7:0]  r_obyte, n_obyte;
    logic        r_olast, n_olast;
    logic [15:0] r_orec, n_orec;
    logic [15:0] r_oacc, n_oacc;

    logic        s_accept;
    logic        move;
    logic        issue;
    logic        emit_v;
    t_verdict    v_code;
    logic [8:0]  lim;
    logic [6:0]  pay_len;
    logic [6:0]  widx_inc;
    logic [7:0]  src_byte;
    t_src        isrc;

    assign o_s_tready = (r_phase != PH_EMIT) && !r_rv && (!r_ov || i_m_tready);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign move       = r_rv && (!r_ov || i_m_tready);
    assign issue      = (r_phase == PH_EMIT) && (!r_rv || move);
    assign lim        = (9'(i_cfg.max_buffer_len) > BUF_CAP) ? BUF_CAP
                                                              : 9'(i_cfg.max_buffer_len);
    assign pay_len    = r_expect - 7'd2;
    assign widx_inc   = r_widx + 7'd1;

    always_comb begin
        unique case (r_rsrc)
            SRC_MEM:  src_byte = i_rdata;
            SRC_STAT: src_byte = r_stat & STAT_MASK;
            SRC_SWAP: src_byte = r_prev + STAT_ADD;
            default:  src_byte = i_rdata;
        endcase
    end

    always_comb begin
        if (r_eidx < pay_len) begin
            isrc = SRC_MEM;
        end else if (r_eidx == pay_len) begin
            isrc = SRC_STAT;
        end else begin
            isrc = SRC_SWAP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT;
            r_widx   <= '0;
            r_expect <= '0;
            r_rec    <= '0;
            r_acc    <= '0;
            r_rv     <= 1'b0;
            r_ov     <= 1'b0;
            r_eidx   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_widx   <= n_widx;
            r_expect <= n_expect;
            r_rec    <= n_rec;
            r_acc    <= n_acc;
            r_rv     <= n_rv;
            r_ov     <= n_ov;
            r_eidx   <= n_eidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sid     <= n_sid;
        r_prev    <= n_prev;
        r_stat    <= n_stat;
        r_rsrc    <= n_rsrc;
        r_rlast   <= n_rlast;
        r_verdict <= n_verdict;
        r_obyte   <= n_obyte;
        r_olast   <= n_olast;
        r_orec    <= n_orec;
        r_oacc    <= n_oacc;
    end

    always_comb begin
        n_phase   = r_phase;
        n_widx    = r_widx;
        n_expect  = r_expect;
        n_eidx    = r_eidx;
        n_rec     = r_rec;
        n_acc     = r_acc;
        n_sid     = r_sid;
        n_prev    = r_prev;
        n_stat    = r_stat;
        n_rv      = r_rv;
        n_rsrc    = r_rsrc;
        n_rlast   = r_rlast;
        n_ov      = r_ov && !i_m_tready;
        n_verdict = r_verdict;
        n_obyte   = r_obyte;
        n_olast   = r_olast;
        n_orec    = r_orec;
        n_oacc    = r_oacc;
        emit_v    = 1'b0;
        v_code    = V_ACCEPT;
        o_req     = '0;

        // emission: walk the store, last two bytes come from the status registers
        if (issue) begin
            o_req.re    = (isrc == SRC_MEM);
            o_req.raddr = r_eidx;
            n_rv        = 1'b1;
            n_rsrc      = isrc;
            n_rlast     = (r_eidx == r_expect - 7'd1);
            n_eidx      = r_eidx + 7'd1;
            if (r_eidx == r_expect - 7'd1) begin
                n_phase = PH_WAIT;
            end
        end else if (move) begin
            n_rv = 1'b0;
        end

        if (move) begin
            n_ov      = 1'b1;
            n_verdict = V_ACCEPT;
            n_obyte   = src_byte;
            n_olast   = r_rlast;
            n_orec    = r_rec;
            n_oacc    = r_acc;
        end

        if (s_accept) begin
            if (i_first) begin
                n_phase = PH_WAIT;
                if (!i_cfg.rx_enabled) begin
                    emit_v = 1'b1;
                    v_code = V_RX_OFF;
                end else if (!i_idle) begin
                    emit_v = 1'b1;
                    v_code = V_BAD_STATUS;
                end else begin
                    // counters wrap together
                    if (r_rec == CNT_MAX) begin
                        n_rec = 16'd1;
                        n_acc = '0;
                    end else begin
                        n_rec = r_rec + 16'd1;
                    end
                    if (!i_count[0] || (i_count < COUNT_MIN)) begin
                        emit_v = 1'b1;
                        v_code = V_BAD_LENGTH;
                    end else if (i_byte != {1'b0, i_count - LEN_OFFSET}) begin
                        emit_v = 1'b1;
                        v_code = V_MISMATCH;
                    end else if (9'(i_count - 7'd1) > lim) begin
                        emit_v = 1'b1;
                        v_code = V_TOO_LONG;
                    end else begin
                        n_expect = i_count - 7'd1;
                        n_widx   = '0;
                        n_phase  = PH_RECV;
                    end
                end
            end else if (r_phase == PH_RECV) begin
                o_req.we    = 1'b1;
                o_req.waddr = r_widx;
                o_req.wdata = i_byte;
                n_widx      = widx_inc;
                if (r_widx == 7'd0) begin
                    n_sid[7:0] = i_byte;
                end
                if (r_widx == 7'd1) begin
                    n_sid[15:8] = i_byte;
                end
                if (widx_inc >= r_expect) begin
                    n_phase = PH_WAIT;
                    if ((i_cfg.station_id != ID_NONE) && (i_cfg.station_id != ID_ALL) &&
                        (r_sid != ID_NONE) && (r_sid != i_cfg.station_id)) begin
                        emit_v = 1'b1;
                        v_code = V_STATION;
                    end else if (!i_byte[7]) begin
                        emit_v = 1'b1;
                        v_code = V_CRC;
                    end else begin
                        n_acc   = r_acc + 16'd1;
                        n_stat  = i_byte;
                        n_eidx  = '0;
                        n_phase = PH_EMIT;
                    end
                end else begin
                    n_prev = i_byte;
                end
            end
        end

        if (emit_v) begin
            n_ov      = 1'b1;
            n_verdict = v_code;
            n_obyte   = '0;
            n_olast   = 1'b1;
            n_orec    = n_rec;
            n_oacc    = n_acc;
        end
    end

    assign o_m_tvalid    = r_ov;
    assign o_verdict     = r_verdict;
    assign o_byte        = r_obyte;
    assign o_last        = r_olast;
    assign o_needs_reset = (r_verdict == V_BAD_STATUS) || (r_verdict == V_BAD_LENGTH) ||
                           (r_verdict == V_MISMATCH) || (r_verdict == V_TOO_LONG);
    assign o_rec         = r_orec;
    assign o_acc         = r_oacc;

endmodule

FILE: sv/radio_rx_packet_filter_core.sv
// radio_rx_packet_filter_core: top level of the receive packet filter
//
// takes receive fifo bytes one word per cycle on the slave stream while
// s_axis_tready is high. a word with tuser set is the length byte of a packet
// and carries the fifo count and the chip idle flag; the header is checked in
// that cycle and a rejected packet gives one verdict word. otherwise the
// following count-1 words are written into the packet store, one per cycle
// while the slave side is not held off. after the last one the station id and
// crc-ok bit are checked: a failure gives one verdict word, a pass emits the
// packet as count-1 words back to back, one per cycle while the master side
// does not stall, from the store's single registered read port, with the two
// status bytes rewritten. while an accepted packet is emitted the slave side is
// held off, so one packet of n stored bytes takes n+1 input words (length byte
// included) and then holds the slave side off while its n words leave. a
// verdict or a data word waits in the output register; input is taken while
// that register drains. the store needs no clearing pass: every read hits an
// entry written earlier in the same packet. counters travel with every word.
module radio_rx_packet_filter_core #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // fifo_count[6:0], chip_idle[7], data_byte[15:8]
    input  logic        s_axis_tuser,   // first_byte
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_byte[7:0], reception_count[23:8],
                                        // accepted_count[39:24]
    output logic [3:0]  m_axis_tuser,   // verdict[2:0], needs_reset[3]
    output logic        m_axis_tlast    // out_last
);
    import rxpf_pkg::*;

    t_cfg       r_cfg;
    t_mem_req   mem_req;
    logic [7:0] mem_rdata;
    logic [2:0] verdict;
    logic [7:0] out_byte;
    logic       needs_reset;
    logic [15:0] rec_cnt;
    logic [15:0] acc_cnt;

    // config registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rx_enabled     <= 1'b0;
            r_cfg.station_id     <= ID_NONE;
            r_cfg.max_buffer_len <= MAX_LEN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RX_ENABLED:     r_cfg.rx_enabled     <= i_cfg_data[0];
                CFG_STATION_ID:     r_cfg.station_id     <= i_cfg_data;
                CFG_MAX_BUFFER_LEN: r_cfg.max_buffer_len <= i_cfg_data[5:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    rxpf_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_s_tvalid    (s_axis_tvalid),
        .o_s_tready    (s_axis_tready),
        .i_first       (s_axis_tuser),
        .i_count       (s_axis_tdata[6:0]),
        .i_idle        (s_axis_tdata[7]),
        .i_byte        (s_axis_tdata[15:8]),
        .o_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .o_verdict     (verdict),
        .o_byte        (out_byte),
        .o_last        (m_axis_tlast),
        .o_needs_reset (needs_reset),
        .o_rec         (rec_cnt),
        .o_acc         (acc_cnt),
        .o_req         (mem_req),
        .i_rdata       (mem_rdata)
    );

    rxpf_store #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // output word packing
    assign m_axis_tdata = {acc_cnt, rec_cnt, out_byte};
    assign m_axis_tuser = {needs_reset, verdict};

endmodule

FILE: sv/rxpf_checker.sv
// rxpf_checker: port-level assertions for the packet filter, bound to the top
module rxpf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    // output register empties on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled output word changed");

    // no input while the output register is stuck
    a_no_take_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // a drop verdict is a single zero word
    a_drop_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] != 3'd0) |->
            m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
        else $error("drop verdict not a single zero word");

    // reset-needed flag follows the verdict
    a_needs_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[3] == ((m_axis_tuser[2:0] == 3'd2) ||
            (m_axis_tuser[2:0] == 3'd3) || (m_axis_tuser[2:0] == 3'd4) ||
            (m_axis_tuser[2:0] == 3'd5)))
        else $error("needs_reset disagrees with verdict");

endmodule

bind radio_rx_packet_filter_core rxpf_checker u_rxpf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
